### sv/svib_pkg.sv
// Shared types, constants and helpers of the shadow volume index builder.
`default_nettype none

package svib_pkg;

	// Mesh limits and field widths.
	localparam int MAX_TRIS = 4096;
	localparam int TRI_AW   = $clog2(MAX_TRIS);
	localparam int CORNER_W = 12;
	localparam int IDX_W    = 13;
	localparam int CNT_W    = 16;

	// Item commands.
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EMIT = 1'b1;

	// Register index decoded from paddr[2].
	localparam logic REG_VERTEX_COUNT = 1'b0;

	// Controller states.
	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_RTRI = 7'b0000010,
		S_RN0  = 7'b0000100,
		S_RN1  = 7'b0001000,
		S_RN2  = 7'b0010000,
		S_DEC  = 7'b0100000,
		S_EMIT = 7'b1000000
	} state_t;

	// Which index addresses the facing memory.
	typedef enum logic [1:0] {
		RD_TRI = 2'd0,
		RD_N0  = 2'd1,
		RD_N1  = 2'd2,
		RD_N2  = 2'd3
	} rd_sel_t;

	// Which flag the registered memory data goes to.
	typedef enum logic [1:0] {
		CAP_LIT = 2'd0,
		CAP_O0  = 2'd1,
		CAP_O1  = 2'd2,
		CAP_O2  = 2'd3
	} cap_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     take;
		rd_sel_t  rd_sel;
		logic     cap_en;
		cap_sel_t cap_sel;
		logic     emit;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_emit;
		logic lit;
		logic out_free;
		logic slot_last;
	} ctrl_sts_t;

	// True when a triangle index addresses a stored facing flag.
	function automatic logic tri_in_range(input logic [CORNER_W-1:0] t);
		return 32'(t) < MAX_TRIS;
	endfunction

endpackage

`default_nettype wire

### sv/svib_ctrl.sv
// Controller state machine: sequences flag lookups and result words.
`default_nettype none

module svib_ctrl import svib_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire ctrl_sts_t sts,
	output ctrl_cmd_t      cmd
);

	state_t state_q;
	state_t state_d;

	// Next state and command decode.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					if (sts.in_emit) begin
						state_d = S_RTRI;
					end
				end
			end
			S_RTRI: begin
				cmd.rd_sel = RD_TRI;
				state_d    = S_RN0;
			end
			S_RN0: begin
				cmd.rd_sel  = RD_N0;
				cmd.cap_en  = 1'b1;
				cmd.cap_sel = CAP_LIT;
				state_d     = S_RN1;
			end
			S_RN1: begin
				cmd.rd_sel  = RD_N1;
				cmd.cap_en  = 1'b1;
				cmd.cap_sel = CAP_O0;
				state_d     = S_RN2;
			end
			S_RN2: begin
				cmd.rd_sel  = RD_N2;
				cmd.cap_en  = 1'b1;
				cmd.cap_sel = CAP_O1;
				state_d     = S_DEC;
			end
			S_DEC: begin
				cmd.cap_en  = 1'b1;
				cmd.cap_sel = CAP_O2;
				state_d     = sts.lit ? S_EMIT : S_IDLE;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.slot_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

### sv/svib_dpath.sv
// Datapath: facing memory, item registers, triangle builder and output register.
`default_nettype none

module svib_dpath import svib_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ctrl_cmd_t           cmd,
	output ctrl_sts_t                sts,
	input  wire logic [IDX_W-1:0]    vertex_count,
	input  wire logic                in_cmd,
	input  wire logic [CORNER_W-1:0] in_tri,
	input  wire logic                in_faces,
	input  wire logic [CORNER_W-1:0] in_c0,
	input  wire logic [CORNER_W-1:0] in_c1,
	input  wire logic [CORNER_W-1:0] in_c2,
	input  wire logic [IDX_W-1:0]    in_n0,
	input  wire logic [IDX_W-1:0]    in_n1,
	input  wire logic [IDX_W-1:0]    in_n2,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [IDX_W-1:0]         out_a,
	output logic [IDX_W-1:0]         out_b,
	output logic [IDX_W-1:0]         out_c,
	output logic [CNT_W-1:0]         out_count,
	output logic                     out_last
);

	logic                tri_mem [MAX_TRIS];
	logic                rd_q;
	logic [TRI_AW-1:0]   rd_addr;
	logic [CORNER_W-1:0] rd_idx;
	logic                load_take;

	logic [CORNER_W-1:0] tri_q;
	logic [CORNER_W-1:0] c0_q;
	logic [CORNER_W-1:0] c1_q;
	logic [CORNER_W-1:0] c2_q;
	logic [IDX_W-1:0]    n0_q;
	logic [IDX_W-1:0]    n1_q;
	logic [IDX_W-1:0]    n2_q;

	logic                lit_q;
	logic [2:0]          open_q;
	logic [1:0]          pair_q;
	logic                half_q;
	logic [CNT_W-1:0]    total_q;
	logic                out_valid_q;
	logic [IDX_W-1:0]    out_a_q;
	logic [IDX_W-1:0]    out_b_q;
	logic [IDX_W-1:0]    out_c_q;
	logic [CNT_W-1:0]    out_count_q;
	logic                out_last_q;

	logic [3:0]          pair_en;
	logic [3:0]          later;
	logic [1:0]          next_pair;
	logic                slot_last;
	logic [CNT_W-1:0]    total_nxt;
	logic [IDX_W-1:0]    p_idx;
	logic [IDX_W-1:0]    q_idx;
	logic [IDX_W-1:0]    p_ext;
	logic [IDX_W-1:0]    q_ext;
	logic [IDX_W-1:0]    e0;
	logic [IDX_W-1:0]    e1;
	logic [IDX_W-1:0]    e2;
	logic [IDX_W-1:0]    tri_a;
	logic [IDX_W-1:0]    tri_b;
	logic [IDX_W-1:0]    tri_c;
	logic                edge_open;
	logic [IDX_W-1:0]    cap_nb;

	assign load_take = cmd.take && (in_cmd == CMD_LOAD);

	// Item registers, loaded when the controller takes a word.
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			tri_q <= in_tri;
			c0_q  <= in_c0;
			c1_q  <= in_c1;
			c2_q  <= in_c2;
			n0_q  <= in_n0;
			n1_q  <= in_n1;
			n2_q  <= in_n2;
		end
	end

	// Lookup address select.
	always_comb begin
		case (cmd.rd_sel)
			RD_TRI:  rd_idx = tri_q;
			RD_N0:   rd_idx = n0_q[CORNER_W-1:0];
			RD_N1:   rd_idx = n1_q[CORNER_W-1:0];
			default: rd_idx = n2_q[CORNER_W-1:0];
		endcase
	end

	assign rd_addr = TRI_AW'(rd_idx);

	// Facing flag memory: a load writes directly from the input port.
	always_ff @(posedge clk) begin
		if (load_take && tri_in_range(in_tri)) begin
			tri_mem[TRI_AW'(in_tri)] <= in_faces;
		end
		rd_q <= tri_mem[rd_addr];
	end

	// Neighbor whose flag is in rd_q this cycle.
	always_comb begin
		case (cmd.cap_sel)
			CAP_O0:  cap_nb = n0_q;
			CAP_O1:  cap_nb = n1_q;
			default: cap_nb = n2_q;
		endcase
	end

	// An edge is open when the neighbor is missing, out of range or unlit.
	assign edge_open = cap_nb[IDX_W-1] || !tri_in_range(cap_nb[CORNER_W-1:0]) || !rd_q;

	// Captured flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lit_q  <= 1'b0;
			open_q <= '0;
		end else if (cmd.cap_en) begin
			case (cmd.cap_sel)
				CAP_LIT: lit_q     <= rd_q && tri_in_range(tri_q);
				CAP_O0:  open_q[0] <= edge_open;
				CAP_O1:  open_q[1] <= edge_open;
				default: open_q[2] <= edge_open;
			endcase
		end
	end

	// Slot walk: pair 0 holds both caps, pairs 1 to 3 the sides of open edges.
	assign pair_en = {open_q, 1'b1};
	assign later   = pair_en & (4'b1110 << pair_q);
	assign slot_last = half_q && (later == 4'b0000);

	always_comb begin
		if (later[1]) begin
			next_pair = 2'd1;
		end else if (later[2]) begin
			next_pair = 2'd2;
		end else begin
			next_pair = 2'd3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_q <= '0;
			half_q <= 1'b0;
		end else if (cmd.take) begin
			pair_q <= '0;
			half_q <= 1'b0;
		end else if (cmd.emit) begin
			if (!half_q) begin
				half_q <= 1'b1;
			end else begin
				pair_q <= next_pair;
				half_q <= 1'b0;
			end
		end
	end

	// Extruded copies of the corners, wrapping in the index width.
	assign e0 = {1'b0, c0_q} + vertex_count;
	assign e1 = {1'b0, c1_q} + vertex_count;
	assign e2 = {1'b0, c2_q} + vertex_count;

	// Edge endpoints for the side pairs.
	always_comb begin
		case (pair_q)
			2'd1: begin
				p_idx = {1'b0, c0_q};
				q_idx = {1'b0, c1_q};
				p_ext = e0;
				q_ext = e1;
			end
			2'd2: begin
				p_idx = {1'b0, c1_q};
				q_idx = {1'b0, c2_q};
				p_ext = e1;
				q_ext = e2;
			end
			default: begin
				p_idx = {1'b0, c2_q};
				q_idx = {1'b0, c0_q};
				p_ext = e2;
				q_ext = e0;
			end
		endcase
	end

	// Triangle for the current slot.
	always_comb begin
		if (pair_q == 2'd0) begin
			if (!half_q) begin
				tri_a = {1'b0, c0_q};
				tri_b = {1'b0, c1_q};
				tri_c = {1'b0, c2_q};
			end else begin
				tri_a = e0;
				tri_b = e2;
				tri_c = e1;
			end
		end else if (!half_q) begin
			tri_a = q_idx;
			tri_b = p_idx;
			tri_c = p_ext;
		end else begin
			tri_a = q_idx;
			tri_b = p_ext;
			tri_c = q_ext;
		end
	end

	// Saturating running count.
	assign total_nxt = (total_q == {CNT_W{1'b1}}) ? total_q : total_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (load_take) begin
			total_q <= '0;
		end else if (cmd.emit) begin
			total_q <= total_nxt;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_a_q     <= tri_a;
			out_b_q     <= tri_b;
			out_c_q     <= tri_c;
			out_count_q <= total_nxt;
			out_last_q  <= slot_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_a     = out_a_q;
	assign out_b     = out_b_q;
	assign out_c     = out_c_q;
	assign out_count = out_count_q;
	assign out_last  = out_last_q;

	// Status to the controller.
	assign sts.in_emit   = (in_cmd == CMD_EMIT);
	assign sts.lit       = lit_q;
	assign sts.out_free  = !out_valid_q || out_ready;
	assign sts.slot_last = slot_last;

endmodule

`default_nettype wire

### sv/shadow_volume_index_builder.sv
// Top level of the shadow volume index builder: register port, controller and datapath.
//
// Input channel (in_valid/in_ready) takes one word per item. A load word
// (cmd 0) stores the facing flag of one triangle and clears the running
// count; it gives no result, and the block stays idle for the next word.
// An emit word (cmd 1) looks up four facing flags one after the other in a
// flag memory with one read port (the triangle and its three neighbors);
// then, if the triangle is lit, it sends 2 to 8 result words on the output
// channel (out_valid/out_ready) at one word per cycle while the receiver
// takes them, with run_last on the last. An emit word thus occupies the
// block until its lookups end when the triangle is unlit, and otherwise
// until its last word is in the output register, when in_ready rises
// again, so the next word is taken while that result still waits. When
// the receiver stalls, the output register holds its word and the walk
// through the slots pauses. Reset clears the controller, the output
// valid, the running count and vertex_count; the facing flags keep no
// reset value and must be loaded before they are used.
`default_nettype none

module shadow_volume_index_builder import svib_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// Configuration port
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [2:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,
	// Input channel
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic                cmd,
	input  wire logic [CORNER_W-1:0] triangle_number,
	input  wire logic                faces_light,
	input  wire logic [CORNER_W-1:0] corner0,
	input  wire logic [CORNER_W-1:0] corner1,
	input  wire logic [CORNER_W-1:0] corner2,
	input  wire logic [IDX_W-1:0]    neighbor0,
	input  wire logic [IDX_W-1:0]    neighbor1,
	input  wire logic [IDX_W-1:0]    neighbor2,
	// Output channel
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [IDX_W-1:0]         out_a,
	output logic [IDX_W-1:0]         out_b,
	output logic [IDX_W-1:0]         out_c,
	output logic [CNT_W-1:0]         volume_count,
	output logic                     run_last
);

	logic [IDX_W-1:0] vertex_count_q;
	ctrl_cmd_t        ctl_cmd;
	ctrl_sts_t        ctl_sts;

	// Register write and read.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= '0;
		end else if (psel && penable && pwrite && (paddr[2] == REG_VERTEX_COUNT)) begin
			vertex_count_q <= pwdata[IDX_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? {{(32 - IDX_W){1'b0}}, vertex_count_q}
	                                              : 32'd0;

	svib_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (ctl_sts),
		.cmd      (ctl_cmd)
	);

	svib_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (ctl_cmd),
		.sts          (ctl_sts),
		.vertex_count (vertex_count_q),
		.in_cmd       (cmd),
		.in_tri       (triangle_number),
		.in_faces     (faces_light),
		.in_c0        (corner0),
		.in_c1        (corner1),
		.in_c2        (corner2),
		.in_n0        (neighbor0),
		.in_n1        (neighbor1),
		.in_n2        (neighbor2),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_a        (out_a),
		.out_b        (out_b),
		.out_c        (out_c),
		.out_count    (volume_count),
		.out_last     (run_last)
	);

	// A result word always counts at least itself.
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (volume_count != '0))
		else $error("result word with zero volume_count");

	// A load word leaves the block ready for the next word.
	a_load_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (cmd == CMD_LOAD)) |=> in_ready)
		else $error("load word did not complete in one cycle");

	// An emit word blocks the input while its flags are looked up.
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (cmd == CMD_EMIT)) |=> !in_ready)
		else $error("input taken during flag lookup");

endmodule

`default_nettype wire

### sim/shadow_volume_index_builder_test.sv
// Self-checking testbench of the shadow volume index builder, with its own index predictor.
`timescale 1ns / 1ps

module shadow_volume_index_builder_test import svib_pkg::*; ();

	localparam int          CYCLE_LIMIT  = 2000000;
	localparam int          IDLE_PCT     = 33;
	localparam int          HOLD_CYCLES  = 300;
	localparam int          RAND_WORDS   = 41;
	localparam int          SETTLE_TICKS = 20;
	localparam logic [2:0]  ADDR_VERTEX_COUNT = {REG_VERTEX_COUNT, 2'b00};
	localparam logic [IDX_W-1:0] NO_NEIGHBOR = '1;

	// One input word and one emitted volume triangle.
	typedef struct packed {
		logic                cmd;
		logic [CORNER_W-1:0] tri_num;
		logic                face;
		logic [CORNER_W-1:0] c0, c1, c2;
		logic [IDX_W-1:0]    nb0, nb1, nb2;
	} word_t;

	typedef struct packed {
		logic [IDX_W-1:0] a, b, c;
		logic [CNT_W-1:0] count;
		logic             last;
	} vol_tri_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [2:0]          paddr = '0;
	logic [31:0]         pwdata = '0;
	logic [31:0]         prdata;
	logic                pready;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic                cmd = CMD_LOAD;
	logic [CORNER_W-1:0] triangle_number = '0;
	logic                faces_light = 1'b0;
	logic [CORNER_W-1:0] corner0 = '0;
	logic [CORNER_W-1:0] corner1 = '0;
	logic [CORNER_W-1:0] corner2 = '0;
	logic [IDX_W-1:0]    neighbor0 = '0;
	logic [IDX_W-1:0]    neighbor1 = '0;
	logic [IDX_W-1:0]    neighbor2 = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [IDX_W-1:0]    out_a;
	logic [IDX_W-1:0]    out_b;
	logic [IDX_W-1:0]    out_c;
	logic [CNT_W-1:0]    volume_count;
	logic                run_last;

	shadow_volume_index_builder u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .triangle_number(triangle_number), .faces_light(faces_light),
		.corner0(corner0), .corner1(corner1), .corner2(corner2),
		.neighbor0(neighbor0), .neighbor1(neighbor1), .neighbor2(neighbor2),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_a(out_a), .out_b(out_b), .out_c(out_c),
		.volume_count(volume_count), .run_last(run_last)
	);

	always #5 clk = ~clk;

	// Predictor state: facing flags, which flags were loaded, running count, offset.
	logic                facing [MAX_TRIS];
	logic                loaded [MAX_TRIS];
	logic [CORNER_W-1:0] loaded_tris [$];
	logic [CNT_W-1:0]    emitted_total = '0;
	logic [IDX_W-1:0]    vertex_count = '0;
	vol_tri_t            pending_tris [$];

	// Run bookkeeping.
	bit calm = 1'b0;
	int cycles = 0;
	int words_taken = 0;
	int loads_taken = 0;
	int settings = 0;
	int reg_faults = 0;
	int tris_checked = 0;
	int tri_faults = 0;
	int hold_left = 0;
	bit held_once = 1'b0;
	vol_tri_t got;
	vol_tri_t want;

	// Directed words: cmd, triangle, face, corners, neighbors, typed result count
	// (-1 leaves it to the predictor), front cap, rear cap and count of the front cap.
	localparam int DIR_ROWS = 15;
	int dir_tab [DIR_ROWS][17] = '{
		'{0,    0, 1,    0,    0,    0,    0,    0,    0,  0, 0,0,0, 0,0,0, 0},
		'{0, 4095, 1,    0,    0,    0,    0,    0,    0,  0, 0,0,0, 0,0,0, 0},
		'{0,    1, 0,    0,    0,    0,    0,    0,    0,  0, 0,0,0, 0,0,0, 0},
		'{0,    2, 1,    0,    0,    0,    0,    0,    0,  0, 0,0,0, 0,0,0, 0},
		'{1,    1, 0,    5,    6,    7,   -1,   -1,   -1,  0, 0,0,0, 0,0,0, 0},
		'{1,    0, 0,    1,    2,    3, 4095,    2,    0,  2, 1,2,3, 1,3,2, 1},
		'{1, 4095, 0, 4095, 4095, 4095,   -1,   -1,   -1, -1, 0,0,0, 0,0,0, 0},
		'{1,    0, 0,    0,    0,    0,    1,   -1,    2, -1, 0,0,0, 0,0,0, 0},
		'{1,    2, 0, 4095,    0, 2730,    1,    2, 4095, -1, 0,0,0, 0,0,0, 0},
		'{0,    2, 0,    0,    0,    0,    0,    0,    0,  0, 0,0,0, 0,0,0, 0},
		'{1,    2, 0,    1,    1,    1,    0,    0,    0,  0, 0,0,0, 0,0,0, 0},
		'{1,    0, 0,   10,   20,   30,    0,    0, 4095,  2, 10,20,30, 10,30,20, 1},
		'{0,    2, 1,    0,    0,    0,    0,    0,    0,  0, 0,0,0, 0,0,0, 0},
		'{1,    0, 0, 4095, 1365, 2730,    1,    1,    1, -1, 0,0,0, 0,0,0, 0},
		'{1, 4095, 0,    0, 4095,    0,    2, 4095,    0,  2, 0,4095,0, 0,0,4095, 9}
	};

	// Appends one volume triangle to a run, advancing the saturating count.
	task automatic put_tri(ref vol_tri_t run [$], input logic [IDX_W-1:0] a, b, c);
		vol_tri_t t;
		if (emitted_total != '1)
			emitted_total = emitted_total + 1'b1;
		t.a = a;
		t.b = b;
		t.c = c;
		t.count = emitted_total;
		t.last = 1'b0;
		run.push_back(t);
	endtask

	function automatic logic [IDX_W-1:0] lift(input logic [CORNER_W-1:0] corner);
		return {1'b0, corner} + vertex_count;
	endfunction

	// An edge is open when it has no neighbor or the neighbor is unlit.
	function automatic logic edge_open(input logic [IDX_W-1:0] nb);
		return nb[IDX_W-1] || !facing[nb[CORNER_W-1:0]];
	endfunction

	// Two side triangles joining edge p-q to its extruded copy.
	task automatic put_side(ref vol_tri_t run [$], input logic [CORNER_W-1:0] p, q);
		put_tri(run, {1'b0, q}, {1'b0, p}, lift(p));
		put_tri(run, {1'b0, q}, lift(p), lift(q));
	endtask

	// Updates the predicted state for one accepted word and, if asked, queues its triangles.
	task automatic build_volume(input word_t w, input bit keep);
		vol_tri_t run [$];
		if (w.cmd == CMD_LOAD) begin
			facing[w.tri_num] = w.face;
			if (!loaded[w.tri_num]) begin
				loaded[w.tri_num] = 1'b1;
				loaded_tris.push_back(w.tri_num);
			end
			emitted_total = '0;
			return;
		end
		if (!facing[w.tri_num])
			return;
		put_tri(run, {1'b0, w.c0}, {1'b0, w.c1}, {1'b0, w.c2});
		put_tri(run, lift(w.c0), lift(w.c2), lift(w.c1));
		if (edge_open(w.nb0))
			put_side(run, w.c0, w.c1);
		if (edge_open(w.nb1))
			put_side(run, w.c1, w.c2);
		if (edge_open(w.nb2))
			put_side(run, w.c2, w.c0);
		run[run.size()-1].last = 1'b1;
		if (keep)
			foreach (run[i])
				pending_tris.push_back(run[i]);
	endtask

	// Offers one word after a random gap and returns at the edge that takes it.
	task automatic send_word(input word_t w);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		cmd             <= w.cmd;
		triangle_number <= w.tri_num;
		faces_light     <= w.face;
		corner0         <= w.c0;
		corner1         <= w.c1;
		corner2         <= w.c2;
		neighbor0       <= w.nb0;
		neighbor1       <= w.nb1;
		neighbor2       <= w.nb2;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		words_taken++;
		if (w.cmd == CMD_LOAD)
			loads_taken++;
	endtask

	function automatic logic [CORNER_W-1:0] pick_corner();
		int roll;
		roll = $urandom_range(99);
		if (roll < 15)
			return '0;
		if (roll < 30)
			return '1;
		return CORNER_W'($urandom_range(4095));
	endfunction

	// Neighbors point only at loaded triangles, or at none.
	function automatic logic [IDX_W-1:0] pick_neighbor();
		if ($urandom_range(99) < 30)
			return NO_NEIGHBOR;
		return {1'b0, loaded_tris[$urandom_range(loaded_tris.size() - 1)]};
	endfunction

	// Mostly emits of loaded triangles, with loads spread over the whole mesh.
	task automatic rand_word(output word_t w);
		w = '0;
		if (loaded_tris.size() == 0 || $urandom_range(99) < 25) begin
			w.cmd = CMD_LOAD;
			if (loaded_tris.size() != 0 && $urandom_range(1) == 1)
				w.tri_num = loaded_tris[$urandom_range(loaded_tris.size() - 1)];
			else
				w.tri_num = CORNER_W'($urandom_range(4095));
			w.face = ($urandom_range(99) < 70);
		end else begin
			w.cmd = CMD_EMIT;
			w.tri_num = loaded_tris[$urandom_range(loaded_tris.size() - 1)];
			w.face = 1'($urandom_range(1));
			w.c0 = pick_corner();
			w.c1 = pick_corner();
			w.c2 = pick_corner();
			w.nb0 = pick_neighbor();
			w.nb1 = pick_neighbor();
			w.nb2 = pick_neighbor();
		end
	endtask

	// Waits until every expected triangle has come and the block is surely idle.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_tris.size() != 0)
			@(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	// Writes vertex_count over the register port and reads it back.
	task automatic write_vertex_count(input logic [IDX_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_VERTEX_COUNT;
		pwdata  <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		vertex_count = value;
		settings++;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== 32'(value)) begin
			$error("prdata: expected %0d, actual %0d", value, prdata);
			reg_faults++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic random_phase(input logic [IDX_W-1:0] offset, input bit quiet);
		word_t w;
		settle();
		write_vertex_count(offset);
		calm = quiet;
		repeat (RAND_WORDS) begin
			rand_word(w);
			send_word(w);
			build_volume(w, 1'b1);
		end
		calm = 1'b0;
	endtask

	// Receiver: random stalls, one long hold-off, and a check of every word taken.
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			got = '{out_a, out_b, out_c, volume_count, run_last};
			tris_checked++;
			if (pending_tris.size() == 0) begin
				$error("volume triangle with no expectation: %0d %0d %0d count %0d",
					out_a, out_b, out_c, volume_count);
				tri_faults++;
			end else begin
				want = pending_tris.pop_front();
				if (got.a !== want.a) begin
					$error("out_a: expected %0d, actual %0d", want.a, got.a);
					tri_faults++;
				end
				if (got.b !== want.b) begin
					$error("out_b: expected %0d, actual %0d", want.b, got.b);
					tri_faults++;
				end
				if (got.c !== want.c) begin
					$error("out_c: expected %0d, actual %0d", want.c, got.c);
					tri_faults++;
				end
				if (got.count !== want.count) begin
					$error("volume_count: expected %0d, actual %0d", want.count, got.count);
					tri_faults++;
				end
				if (got.last !== want.last) begin
					$error("run_last: expected %0d, actual %0d", want.last, got.last);
					tri_faults++;
				end
			end
		end
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (!held_once && tris_checked >= 50) begin
			held_once <= 1'b1;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Stimulus: directed words, then random phases at several offsets.
	initial begin
		word_t w;
		int typed;
		foreach (facing[i]) begin
			facing[i] = 1'b0;
			loaded[i] = 1'b0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words run with the offset left at its reset value of zero.
		for (int r = 0; r < DIR_ROWS; r++) begin
			w.cmd     = 1'(dir_tab[r][0]);
			w.tri_num = CORNER_W'(dir_tab[r][1]);
			w.face    = 1'(dir_tab[r][2]);
			w.c0      = CORNER_W'(dir_tab[r][3]);
			w.c1      = CORNER_W'(dir_tab[r][4]);
			w.c2      = CORNER_W'(dir_tab[r][5]);
			w.nb0     = IDX_W'(dir_tab[r][6]);
			w.nb1     = IDX_W'(dir_tab[r][7]);
			w.nb2     = IDX_W'(dir_tab[r][8]);
			typed     = dir_tab[r][9];
			send_word(w);
			build_volume(w, typed < 0);
			if (typed == 2) begin
				pending_tris.push_back('{IDX_W'(dir_tab[r][10]), IDX_W'(dir_tab[r][11]),
					IDX_W'(dir_tab[r][12]), CNT_W'(dir_tab[r][16]), 1'b0});
				pending_tris.push_back('{IDX_W'(dir_tab[r][13]), IDX_W'(dir_tab[r][14]),
					IDX_W'(dir_tab[r][15]), CNT_W'(dir_tab[r][16] + 1), 1'b1});
			end
		end

		random_phase(IDX_W'(4096), 1'b0);
		random_phase(IDX_W'(4095), 1'b1);
		random_phase(IDX_W'(1), 1'b0);
		random_phase(IDX_W'($urandom_range(4094, 2)), 1'b0);
		settle();

		$display("Run covered %0d input words (%0d loads) over %0d offset settings,",
			words_taken, loads_taken, settings);
		$display("with %0d volume triangles checked under random and long stalls.",
			tris_checked);
		if (tri_faults == 0 && reg_faults == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### sim.f
sv/svib_pkg.sv
sv/svib_ctrl.sv
sv/svib_dpath.sv
sv/shadow_volume_index_builder.sv
sim/shadow_volume_index_builder_test.sv
